FILE: sv/packed_strip_index_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packed strip index decoder
// Clocked on i_clk; the checked forms are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_STRIP_INDEX_DECODER_ASSERT_SVH
`define PACKED_STRIP_INDEX_DECODER_ASSERT_SVH

// check a property outside reset
`define PSID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check a property at every edge, reset included
`define PSID_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/psid_pkg.sv
// ----------------------------------------------------------------------------
// psid_pkg
// Types and constants shared by the packed strip index decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psid_pkg;

    localparam int VARINT_BITS    = 32;
    localparam int DIGIT_BITS     = 7;
    localparam int OUT_INDEX_BITS = 16;
    localparam int COUNT_BITS     = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_OVERLONG = 2'd1;
    localparam logic [1:0] FAULT_RANGE    = 2'd2;

    typedef enum logic [3:0] {
        PH_SKIP  = 4'b0001,
        PH_COUNT = 4'b0010,
        PH_OFFS  = 4'b0100,
        PH_IDLE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                   fresh;
        logic                   has_index;
        logic                   done;
        logic                   overlong;
        logic [VARINT_BITS-1:0] value;
    } t_token;

endpackage

`default_nettype wire

FILE: sv/psid_front.sv
// ----------------------------------------------------------------------------
// psid_front
// Assembles varints from the byte stream, tracks the section phase and
// the offset count, and pushes one word per completed offset or section end.
// ----------------------------------------------------------------------------
`default_nettype none

module psid_front #(
    parameter int MAX_VARINT_BYTES = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_section_start,
    output psid_pkg::t_token       o_token,
    output logic                   o_push
);
    import psid_pkg::*;

    localparam int SH_BITS = (MAX_VARINT_BYTES > 1) ? $clog2(MAX_VARINT_BYTES) : 1;
    localparam int BP_BITS = SH_BITS + 3;

    logic [VARINT_BITS-1:0] r_accum, n_accum, b_accum, w_accum;
    logic [SH_BITS-1:0]     r_shift, n_shift, b_shift;
    t_phase                 r_phase, n_phase, b_phase;
    logic [COUNT_BITS-1:0]  r_remaining, n_remaining, b_remaining;
    logic                   r_fresh, n_fresh, b_fresh;
    logic [BP_BITS-1:0]     bitpos;
    logic [VARINT_BITS-1:0] digit;

    always_comb begin
        b_accum     = i_section_start ? '0 : r_accum;
        b_shift     = i_section_start ? '0 : r_shift;
        b_phase     = i_section_start ? PH_SKIP : r_phase;
        b_remaining = i_section_start ? '0 : r_remaining;
        b_fresh     = i_section_start | r_fresh;

        bitpos = BP_BITS'(b_shift) * BP_BITS'(DIGIT_BITS);
        digit  = VARINT_BITS'(i_data_byte[DIGIT_BITS-1:0]) << bitpos[4:0];
        w_accum = (bitpos < BP_BITS'(VARINT_BITS)) ? (b_accum | digit) : b_accum;

        n_accum     = b_accum;
        n_shift     = b_shift;
        n_phase     = b_phase;
        n_remaining = b_remaining;
        o_push      = 1'b0;
        o_token     = '{fresh: b_fresh, has_index: 1'b0, done: 1'b0,
                        overlong: 1'b0, value: w_accum};

        if (b_phase != PH_IDLE) begin
            if (i_data_byte[7]) begin
                if (b_shift == SH_BITS'(MAX_VARINT_BYTES - 1)) begin
                    n_phase          = PH_IDLE;
                    n_accum          = '0;
                    n_shift          = '0;
                    o_push           = 1'b1;
                    o_token.done     = 1'b1;
                    o_token.overlong = 1'b1;
                end else begin
                    n_accum = w_accum;
                    n_shift = b_shift + SH_BITS'(1);
                end
            end else begin
                n_accum = '0;
                n_shift = '0;
                case (b_phase)
                    PH_SKIP: begin
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_remaining = w_accum;
                        if (w_accum == '0) begin
                            n_phase      = PH_IDLE;
                            o_push       = 1'b1;
                            o_token.done = 1'b1;
                        end else begin
                            n_phase = PH_OFFS;
                        end
                    end
                    PH_OFFS: begin
                        n_remaining       = b_remaining - COUNT_BITS'(1);
                        o_push            = 1'b1;
                        o_token.has_index = 1'b1;
                        o_token.done      = (b_remaining == COUNT_BITS'(1));
                        if (b_remaining == COUNT_BITS'(1)) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
        n_fresh = b_fresh & ~o_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_shift     <= '0;
            r_phase     <= PH_SKIP;
            r_remaining <= '0;
            r_fresh     <= 1'b1;
        end else if (i_accept) begin
            r_accum     <= n_accum;
            r_shift     <= n_shift;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_fresh     <= n_fresh;
        end
    end

endmodule

`default_nettype wire

FILE: sv/psid_queue.sv
// ----------------------------------------------------------------------------
// psid_queue
// Short word queue between the varint front end and the index back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psid_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire psid_pkg::t_token  i_token,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output psid_pkg::t_token       o_token
);
    import psid_pkg::*;

    t_token                r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count, n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + QPTR_BITS'(1);
            end
        end
    end

`include "packed_strip_index_decoder_assert.svh"

    `PSID_ASSERT(a_no_overflow, !(i_push && o_full), "push into full queue")
    `PSID_ASSERT(a_no_underflow, i_pop |-> o_valid, "pop from empty queue")
    `PSID_ASSERT(a_count_bound, r_count <= QCNT_BITS'(QUEUE_DEPTH), "count overrun")
    `PSID_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "queue not empty after reset")

endmodule

`default_nettype wire

FILE: sv/psid_back.sv
// ----------------------------------------------------------------------------
// psid_back
// Turns offset words into strip indices, judges triangles, counts them and
// holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psid_back #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire psid_pkg::t_token i_token,
    output logic              o_pop,
    input  wire logic         i_stall,
    output logic              o_valid,
    output logic              o_index_valid,
    output logic [15:0]       o_vertex_index,
    output logic              o_triangle_valid,
    output logic [15:0]       o_corner_first,
    output logic [15:0]       o_corner_second,
    output logic [15:0]       o_corner_third,
    output logic              o_section_done,
    output logic [31:0]       o_triangle_total,
    output logic [1:0]        o_fault
);
    import psid_pkg::*;

    logic [INDEX_BITS-1:0]  r_max, r_prev_two, r_prev_one, r_cur;
    logic [INDEX_BITS-1:0]  n_max, n_prev_two, n_prev_one, n_cur;
    logic [INDEX_BITS-1:0]  b_max, b_prev_one, b_cur;
    logic [COUNT_BITS-1:0]  r_tri, n_tri, b_tri;
    logic                   tv;
    logic                   r_valid;

    always_comb begin
        b_max      = i_token.fresh ? '0 : r_max;
        b_prev_one = i_token.fresh ? '0 : r_prev_one;
        b_cur      = i_token.fresh ? '0 : r_cur;
        b_tri      = i_token.fresh ? '0 : r_tri;

        n_cur      = INDEX_BITS'(VARINT_BITS'(b_max) - i_token.value);
        n_prev_two = b_prev_one;
        n_prev_one = b_cur;
        tv = (n_prev_two != n_prev_one) && (n_prev_one != n_cur) &&
             (n_prev_two != n_cur);
        n_tri = b_tri + COUNT_BITS'(tv);
        n_max = (i_token.value == '0) ? b_max + INDEX_BITS'(1) : b_max;
        if (!i_token.has_index) begin
            n_cur      = b_cur;
            n_prev_two = i_token.fresh ? '0 : r_prev_two;
            n_prev_one = b_prev_one;
            n_tri      = b_tri;
            n_max      = b_max;
            tv         = 1'b0;
        end
    end

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_max      <= '0;
            r_prev_two <= '0;
            r_prev_one <= '0;
            r_cur      <= '0;
            r_tri      <= '0;
        end else begin
            if (o_pop) begin
                r_valid    <= 1'b1;
                r_max      <= n_max;
                r_prev_two <= n_prev_two;
                r_prev_one <= n_prev_one;
                r_cur      <= n_cur;
                r_tri      <= n_tri;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_index_valid    <= i_token.has_index;
            o_vertex_index   <= i_token.has_index ? OUT_INDEX_BITS'(n_cur) : '0;
            o_triangle_valid <= tv;
            o_corner_first   <= tv ? OUT_INDEX_BITS'(n_prev_two) : '0;
            o_corner_second  <= tv ? OUT_INDEX_BITS'(n_prev_one) : '0;
            o_corner_third   <= tv ? OUT_INDEX_BITS'(n_cur) : '0;
            o_section_done   <= i_token.done;
            o_triangle_total <= n_tri;
            if (i_token.overlong) begin
                o_fault <= FAULT_OVERLONG;
            end else if (i_token.has_index &&
                         (i_token.value > VARINT_BITS'(b_max))) begin
                o_fault <= FAULT_RANGE;
            end else begin
                o_fault <= FAULT_NONE;
            end
        end
    end

`include "packed_strip_index_decoder_assert.svh"

    `PSID_ASSERT(a_tri_has_index, (r_valid && o_triangle_valid) |-> o_index_valid,
                 "triangle without index")
    `PSID_ASSERT(a_overlong_ends,
                 (r_valid && o_fault == FAULT_OVERLONG) |-> (o_section_done && !o_index_valid),
                 "overlong fault not ending section")
    `PSID_ASSERT(a_corner_current,
                 (r_valid && o_triangle_valid) |-> (o_corner_third == o_vertex_index),
                 "third corner differs from index")

endmodule

`default_nettype wire

FILE: sv/packed_strip_index_decoder.sv
// A completed offset or section end is queued, then held in the back-end output register.
// Throughput: one byte per cycle while o_stall is low, set by the front-end varint step
// and the back-end index update; a two-word queue sits between and raises o_stall when full.
// Bytes that only extend a varint, or fall after the section end, give no result.
// Reset: synchronous, active low; clears phase, counters, queue and output valid.
// ----------------------------------------------------------------------------
// packed_strip_index_decoder
// Decodes a varint-packed triangle strip index section into indices and triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_strip_index_decoder #(
    parameter int INDEX_BITS       = 16,
    parameter int MAX_VARINT_BYTES = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_section_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_index_valid,
    output logic [15:0]      o_vertex_index,
    output logic             o_triangle_valid,
    output logic [15:0]      o_corner_first,
    output logic [15:0]      o_corner_second,
    output logic [15:0]      o_corner_third,
    output logic             o_section_done,
    output logic [31:0]      o_triangle_total,
    output logic [1:0]       o_fault
);
    import psid_pkg::*;

    t_token f_token, q_token;
    logic   f_push, q_full, q_valid, q_pop, accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    psid_front #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_section_start (i_section_start),
        .o_token         (f_token),
        .o_push          (f_push)
    );

    psid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push && accept),
        .i_token (f_token),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    psid_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_token          (q_token),
        .o_pop            (q_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_index_valid    (o_index_valid),
        .o_vertex_index   (o_vertex_index),
        .o_triangle_valid (o_triangle_valid),
        .o_corner_first   (o_corner_first),
        .o_corner_second  (o_corner_second),
        .o_corner_third   (o_corner_third),
        .o_section_done   (o_section_done),
        .o_triangle_total (o_triangle_total),
        .o_fault          (o_fault)
    );

endmodule

`default_nettype wire
